@@ rtl/lzss_pkg.sv @@
// lzss_pkg: shared constants and types for the LZSS pixel unpacker.
// Used by lzss_ctrl, lzss_dp, lzss_pixel_unpacker and the testbench.
package lzss_pkg;

  localparam int DIST_BITS  = 12;
  localparam int LEN_BITS   = 16 - DIST_BITS;
  localparam int HIST_DEPTH = 1 << DIST_BITS;
  localparam int FILL_BITS  = DIST_BITS + 1;
  localparam int CNT_BITS   = 28;
  localparam int COLOR_BITS = 24;
  localparam int PIX_BITS   = 32;
  localparam int FLAG_COUNT = 8;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_RD,
    ST_WR
  } lzss_state_t;

  typedef struct packed {
    logic set_finish;
    logic load_flags;
    logic hold_byte;
    logic load_lit;
    logic load_token;
    logic mem_rd;
    logic emit;
    logic emit_lit;
    logic next_flag;
  } dp_cmd_t;

  typedef struct packed {
    logic fin;
    logic flags_empty;
    logic flag_lit;
    logic hold_done;
    logic out_free;
    logic last_pix;
  } dp_sts_t;

endpackage

@@ rtl/lzss_byte_if.sv @@
// lzss_byte_if: valid/ready channel carrying one compressed byte.
// Depends on nothing.
interface lzss_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

@@ rtl/lzss_pix_if.sv @@
// lzss_pix_if: valid/ready channel carrying one decoded pixel with markers.
// Depends on nothing.
interface lzss_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic        end_of_run;
  logic        end_of_image;

  modport source (output valid, output pixel_word, output end_of_run,
                  output end_of_image, input ready);
  modport sink (input valid, input pixel_word, input end_of_run,
                input end_of_image, output ready);
endinterface

@@ rtl/lzss_ctrl.sv @@
// lzss_ctrl: decoder state machine; sequences byte intake, literal output
// and read-then-write copy steps. Depends on lzss_pkg.
module lzss_ctrl
  import lzss_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  lzss_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !sts.fin && !sts.flags_empty && sts.hold_done) begin
          state_nxt = sts.flag_lit ? ST_LIT : ST_RD;
        end
      end
      ST_LIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (sts.out_free) begin
          state_nxt = sts.last_pix ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (sts.fin) begin
            cmd.set_finish = 1'b1;
          end else if (sts.flags_empty) begin
            cmd.load_flags = 1'b1;
          end else if (!sts.hold_done) begin
            cmd.hold_byte = 1'b1;
          end else if (sts.flag_lit) begin
            cmd.load_lit = 1'b1;
          end else begin
            cmd.load_token = 1'b1;
          end
        end
      end
      ST_LIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_lit  = 1'b1;
          cmd.next_flag = 1'b1;
        end
      end
      ST_RD: begin
        cmd.mem_rd = 1'b1;
      end
      ST_WR: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.next_flag = sts.last_pix;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/lzss_dp.sv @@
// lzss_dp: datapath; flag and byte holding, history memory, counters and
// the output register. Depends on lzss_pkg.
module lzss_dp
  import lzss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_byte,
  input  logic                  cfg_we,
  input  logic [CNT_BITS-1:0]   cfg_wdata,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [PIX_BITS-1:0]   pixel_word,
  output logic                  end_of_run,
  output logic                  end_of_image
);

  logic [COLOR_BITS-1:0] hist_mem [HIST_DEPTH];

  logic [CNT_BITS-1:0]   total_r;
  logic [CNT_BITS-1:0]   done_r;
  logic [DIST_BITS-1:0]  wpos_r;
  logic [FILL_BITS-1:0]  fill_r;
  logic                  finished_r;
  logic [7:0]            flag_bits_r;
  logic [3:0]            flags_left_r;
  logic [1:0]            phase_r;
  logic [15:0]           held_r;
  logic [COLOR_BITS-1:0] lit_r;
  logic [DIST_BITS-1:0]  src_r;
  logic [LEN_BITS:0]     len_r;
  logic [COLOR_BITS-1:0] rdata_r;
  logic                  rd_ok_r;
  logic                  out_valid_r;
  logic [COLOR_BITS-1:0] out_color_r;
  logic                  out_eor_r;
  logic                  out_eoi_r;

  logic [CNT_BITS-1:0]   done_inc;
  logic                  hit_total;
  logic [15:0]           token;
  logic [COLOR_BITS-1:0] emit_color;

  assign done_inc   = done_r + 1'b1;
  assign hit_total  = (done_inc == total_r);
  assign token      = {in_byte, held_r[7:0]};
  assign emit_color = cmd.emit_lit ? lit_r : (rd_ok_r ? rdata_r : '0);

  assign sts.fin         = finished_r || (done_r >= total_r);
  assign sts.flags_empty = (flags_left_r == 4'd0);
  assign sts.flag_lit    = flag_bits_r[0];
  assign sts.hold_done   = flag_bits_r[0] ? (phase_r == 2'd2) : (phase_r != 2'd0);
  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.last_pix    = (len_r == (LEN_BITS+1)'(1)) || hit_total;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hist_mem[wpos_r] <= emit_color;
    end
    if (cmd.mem_rd) begin
      rdata_r <= hist_mem[src_r];
      rd_ok_r <= ({1'b0, src_r} < fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_lit) begin
      lit_r <= {in_byte, held_r};
    end
    if (cmd.load_token) begin
      src_r <= wpos_r - token[15:LEN_BITS];
      len_r <= {1'b0, token[LEN_BITS-1:0]} + 1'b1;
    end else if (cmd.emit && !cmd.emit_lit) begin
      src_r <= src_r + 1'b1;
      len_r <= len_r - 1'b1;
    end
    if (cmd.emit) begin
      out_color_r <= emit_color;
      out_eor_r   <= cmd.emit_lit || sts.last_pix;
      out_eoi_r   <= hit_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      done_r       <= '0;
      wpos_r       <= '0;
      fill_r       <= '0;
      finished_r   <= 1'b0;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      phase_r      <= '0;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_r <= cfg_wdata;
      end
      if (cmd.set_finish) begin
        finished_r <= 1'b1;
      end
      if (cmd.load_flags) begin
        flag_bits_r  <= in_byte;
        flags_left_r <= 4'(FLAG_COUNT);
        phase_r      <= '0;
        held_r       <= '0;
      end else if (cmd.hold_byte) begin
        if (phase_r == 2'd0) begin
          held_r[7:0] <= in_byte;
        end else begin
          held_r[15:8] <= in_byte;
        end
        phase_r <= phase_r + 1'b1;
      end else if (cmd.next_flag) begin
        flag_bits_r  <= {1'b0, flag_bits_r[7:1]};
        flags_left_r <= flags_left_r - 1'b1;
        phase_r      <= '0;
        held_r       <= '0;
      end
      if (cmd.emit) begin
        done_r <= done_inc;
        wpos_r <= wpos_r + 1'b1;
        if (fill_r != FILL_BITS'(HIST_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
        if (hit_total) begin
          finished_r <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign pixel_word   = {ALPHA_OPAQUE, out_color_r};
  assign end_of_run   = out_eor_r;
  assign end_of_image = out_eoi_r;

endmodule

@@ rtl/lzss_pixel_unpacker.sv @@
// lzss_pixel_unpacker: top level of the LZSS pixel decoder.
// Depends on lzss_pkg, lzss_byte_if, lzss_pix_if, lzss_ctrl and lzss_dp.
//
// in_ch carries the compressed stream (after the size header) one byte per
// transaction; out_ch carries 32-bit pixels with alpha 255, end_of_run on
// the last pixel a byte produces and end_of_image on the pixel that reaches
// total_pixels. cfg_we/cfg_wdata load total_pixels; the user must do so
// only while the block is idle, which the block does not enforce. Flag
// bytes load the flag register and the first bytes of a literal or token
// are held. The third literal byte loads lit_r; ST_LIT emits its pixel
// once the output register is free. Each copy pixel is a read of the
// single-port 4096-entry history followed by its write, and no byte is
// taken before a copy's last pixel is written. Pixels appear in the output
// register in the cycle after they are produced. Reset clears all control
// state; history entries not yet written since reset read as zero colour
// through a fill count, so bytes are taken with no clearing pass first.
// A stalled receiver holds the output register; the decoder waits before
// producing the next pixel. Once the total is reached, later bytes are
// accepted and dropped until reset.
module lzss_pixel_unpacker
  import lzss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  lzss_byte_if.sink           in_ch,
  lzss_pix_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CNT_BITS-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  lzss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzss_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_byte      (in_ch.in_byte),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .pixel_word   (out_ch.pixel_word),
    .end_of_run   (out_ch.end_of_run),
    .end_of_image (out_ch.end_of_image)
  );

endmodule

@@ bench/testbench.sv @@
// testbench: self-checking bench for lzss_pixel_unpacker (compressed bytes in, pixels out).
// Uses lzss_pkg, lzss_byte_if and lzss_pix_if; decodes every accepted byte in a local
// model of the decoder and compares each pixel transaction field by field.
`timescale 1ns / 100ps

module testbench
  import lzss_pkg::*;
();

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [CNT_BITS-1:0] TOTAL_MAX = '1;

  typedef enum int {GRP_MIXED, GRP_LONG, GRP_NOISE} group_kind_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel_word;
    logic                end_of_run;
    logic                end_of_image;
  } pix_exp_t;

  // opening stream: copy before any pixel exists, white and black literals,
  // distance zero, overlapping copy of the last pixel, all-ones token, short copy
  localparam logic [7:0] OPENING [20] = '{
    8'h46, 8'h3F, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h1F, 8'h00, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h24, 8'h00
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CNT_BITS-1:0] cfg_wdata;

  lzss_byte_if byte_ch ();
  lzss_pix_if  pix_ch ();

  lzss_pixel_unpacker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (byte_ch),
    .out_ch    (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // decoder model state
  logic [COLOR_BITS-1:0] hist_colors [HIST_DEPTH];
  logic [DIST_BITS-1:0]  wr_pos     = '0;
  logic [CNT_BITS-1:0]   pix_count  = '0;
  logic [CNT_BITS-1:0]   total_pix  = '0;
  logic [7:0]            flag_reg   = '0;
  logic [3:0]            flags_left = '0;
  logic [1:0]            byte_phase = '0;
  logic [15:0]           held       = '0;
  logic                  image_done = 1'b0;

  pix_exp_t   expected_pixels [$];
  logic [7:0] byte_q [$];
  int         bytes_queued   = 0;
  int         bytes_taken    = 0;
  int         pixels_checked = 0;
  int         mismatches     = 0;
  int         send_gap       = 0;
  int         recv_wait      = 0;
  int         idle_cycles    = 0;
  logic       steady         = 1'b0;
  logic       hold_off       = 1'b0;
  logic       squeeze        = 1'b0;

  initial begin
    clk = 1'b0;
    foreach (hist_colors[i]) hist_colors[i] = '0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pix_exp_t store_color(input logic [COLOR_BITS-1:0] c);
    pix_exp_t p;
    hist_colors[wr_pos] = c;
    wr_pos++;
    pix_count++;
    p.pixel_word   = {ALPHA_OPAQUE, c};
    p.end_of_run   = 1'b0;
    p.end_of_image = (pix_count == total_pix);
    if (p.end_of_image) image_done = 1'b1;
    return p;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [15:0]          tok;
    logic [DIST_BITS-1:0] src;
    int                   remaining;
    pix_exp_t             last_pix;
    bit                   have_pix;
    have_pix = 1'b0;
    if (!image_done && pix_count >= total_pix) image_done = 1'b1;
    if (image_done) return;
    if (flags_left == 0) begin
      flag_reg   = b;
      flags_left = 4'(FLAG_COUNT);
      byte_phase = '0;
      held       = '0;
      return;
    end
    if (flag_reg[0]) begin
      if (byte_phase < 2) begin
        held[8*byte_phase +: 8] = b;
        byte_phase++;
        return;
      end
      last_pix = store_color({b, held});
      have_pix = 1'b1;
    end else begin
      if (byte_phase == 0) begin
        held[7:0]  = b;
        byte_phase = 2'd1;
        return;
      end
      tok       = {b, held[7:0]};
      src       = wr_pos - tok[15:LEN_BITS];
      remaining = int'(tok[LEN_BITS-1:0]) + 1;
      // overlapping copy, cut short at the configured total
      while (remaining > 0 && !image_done) begin
        if (have_pix) expected_pixels.push_back(last_pix);
        last_pix = store_color(hist_colors[src]);
        have_pix = 1'b1;
        src++;
        remaining--;
      end
    end
    flag_reg   = flag_reg >> 1;
    flags_left--;
    byte_phase = '0;
    held       = '0;
    if (have_pix) begin
      last_pix.end_of_run = 1'b1;
      expected_pixels.push_back(last_pix);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    byte_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_group(input group_kind_t kind);
    logic [7:0]           flag;
    logic [DIST_BITS-1:0] back_dist;
    logic [LEN_BITS-1:0]  lenf;
    logic [15:0]          tok;
    if (kind == GRP_NOISE) begin
      repeat ($urandom_range(1, 12)) queue_byte(8'($urandom_range(0, 255)));
      return;
    end
    flag = (kind == GRP_LONG) ? 8'h00 : 8'($urandom_range(0, 255));
    queue_byte(flag);
    for (int i = 0; i < FLAG_COUNT; i++) begin
      if (flag[i]) begin
        repeat (3) queue_byte(8'($urandom_range(0, 255)));
      end else begin
        if (kind == GRP_LONG) begin
          back_dist = DIST_BITS'($urandom_range(0, HIST_DEPTH - 1));
          lenf      = LEN_BITS'($urandom_range(12, 15));
        end else begin
          back_dist = ($urandom_range(0, 9) < 6) ? DIST_BITS'($urandom_range(0, 40))
                                                 : DIST_BITS'($urandom_range(0, HIST_DEPTH - 1));
          lenf      = LEN_BITS'($urandom_range(0, (1 << LEN_BITS) - 1));
        end
        tok = {back_dist, lenf};
        queue_byte(tok[7:0]);
        queue_byte(tok[15:8]);
      end
    end
  endtask

  task automatic write_total(input logic [CNT_BITS-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    total_pix = v;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (bytes_taken != bytes_queued || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_ch.valid <= 1'b0;
      send_gap      <= 0;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (send_gap != 0) begin
        byte_ch.valid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (byte_q.size() != 0) begin
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= byte_q.pop_front();
        send_gap        <= pick_gap();
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // pixel receiver
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      pix_ch.ready <= 1'b0;
      recv_wait    <= 0;
    end else if (hold_off) begin
      pix_ch.ready <= 1'b0;
    end else if (recv_wait != 0) begin
      pix_ch.ready <= 1'b0;
      recv_wait    <= recv_wait - 1;
    end else if (pix_ch.valid && pix_ch.ready) begin
      g = pick_gap();
      pix_ch.ready <= (g == 0);
      recv_wait    <= (g == 0) ? 0 : g - 1;
    end else begin
      pix_ch.ready <= 1'b1;
    end
  end

  // monitor: model update on byte transactions, check on pixel transactions
  always @(posedge clk) begin
    pix_exp_t want;
    if (rst_n) begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.in_byte);
        bytes_taken++;
      end
      if (pix_ch.valid && pix_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixel with nothing pending", pix_ch.pixel_word, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (pix_ch.pixel_word !== want.pixel_word)
            report_mismatch("pixel_word", pix_ch.pixel_word, want.pixel_word);
          if (pix_ch.end_of_run !== want.end_of_run)
            report_mismatch("end_of_run", pix_ch.end_of_run, want.end_of_run);
          if (pix_ch.end_of_image !== want.end_of_image)
            report_mismatch("end_of_image", pix_ch.end_of_image, want.end_of_image);
        end
        pixels_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("lzss_pixel_unpacker regression: fail");
        $finish;
      end
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin
    wait (squeeze);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = '0;
    pix_ch.ready    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_total('0);
    write_total(TOTAL_MAX);
    foreach (OPENING[i]) queue_byte(OPENING[i]);
    wait_drained();

    steady <= 1'b1;
    repeat (2) push_group(GRP_MIXED);
    wait_drained();
    steady <= 1'b0;
    repeat (4) push_group(($urandom_range(0, 3) == 0) ? GRP_NOISE : GRP_MIXED);
    push_group(GRP_MIXED);
    wait_drained();

    // long copies reaching far back into the history
    write_total(CNT_BITS'($urandom_range(50000, 1 << 20)));
    squeeze <= 1'b1;
    repeat (3) push_group(GRP_LONG);
    wait_drained();

    // finish the image a short way ahead, then feed bytes that must be dropped
    write_total(pix_count + CNT_BITS'($urandom_range(30, 90)));
    for (int k = 0; k < 40 && !image_done; k++) begin
      push_group(GRP_MIXED);
      wait_drained();
    end
    push_group(GRP_NOISE);
    wait_drained();
    write_total('0);
    push_group(GRP_MIXED);
    wait_drained();

    if (mismatches == 0) begin
      $display("lzss_pixel_unpacker regression: pass");
    end else begin
      $display("lzss_pixel_unpacker regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lzss_pkg.sv
rtl/lzss_byte_if.sv
rtl/lzss_pix_if.sv
rtl/lzss_ctrl.sv
rtl/lzss_dp.sv
rtl/lzss_pixel_unpacker.sv
bench/testbench.sv
